[rtl/assert_macros.svh]
// Assertion helpers used by cdg_engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define CDG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cdg check failed");

// Checked on every rising edge, reset included.
`define CDG_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("cdg check failed");

`endif

[rtl/cdg_pkg.sv]
package cdg_pkg;

    localparam int FRAME_W  = 300;
    localparam int FRAME_H  = 216;
    localparam int BORDER_W = 6;
    localparam int BORDER_H = 12;

    localparam logic [5:0] GFX_COMMAND = 6'h09;

    localparam logic [5:0] INS_MEM_PRESET    = 6'd1;
    localparam logic [5:0] INS_BORDER        = 6'd2;
    localparam logic [5:0] INS_TILE          = 6'd6;
    localparam logic [5:0] INS_SCROLL_PRESET = 6'd20;
    localparam logic [5:0] INS_SCROLL_COPY   = 6'd24;
    localparam logic [5:0] INS_PAL_LOW       = 6'd30;
    localparam logic [5:0] INS_PAL_HIGH      = 6'd31;
    localparam logic [5:0] INS_TILE_XOR      = 6'd38;

    // Operation codes handed from the front end to the engine.
    localparam logic [3:0] OP_READ          = 4'd0;
    localparam logic [3:0] OP_NOT_GFX       = 4'd1;
    localparam logic [3:0] OP_UNKNOWN       = 4'd2;
    localparam logic [3:0] OP_NOP           = 4'd3;
    localparam logic [3:0] OP_MEM_PRESET    = 4'd4;
    localparam logic [3:0] OP_BORDER        = 4'd5;
    localparam logic [3:0] OP_TILE          = 4'd6;
    localparam logic [3:0] OP_TILE_XOR      = 4'd7;
    localparam logic [3:0] OP_PAL_LOW       = 4'd8;
    localparam logic [3:0] OP_PAL_HIGH      = 4'd9;
    localparam logic [3:0] OP_SCROLL_PRESET = 4'd10;
    localparam logic [3:0] OP_SCROLL_COPY   = 4'd11;

    localparam logic [2:0] STAT_APPLIED = 3'd0;
    localparam logic [2:0] STAT_NOT_GFX = 3'd1;
    localparam logic [2:0] STAT_RANGE   = 3'd2;
    localparam logic [2:0] STAT_UNKNOWN = 3'd3;
    localparam logic [2:0] STAT_READ    = 3'd4;

    typedef struct packed {
        logic [3:0]   op;
        logic [127:0] data;
        logic [8:0]   rx;
        logic [7:0]   ry;
    } cdg_cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  index;
        logic [23:0] rgb;
    } cdg_result_t;

endpackage

[rtl/cdg_front.sv]
module cdg_front
    import cdg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [167:0] s_tdata,
    input  logic         s_tuser,
    input  logic         clearing,
    output cdg_cmd_t     cmd,
    output logic         cmd_valid,
    input  logic         cmd_ready
);

    logic     hold_valid_reg;
    cdg_cmd_t hold_reg;
    cdg_cmd_t cls;
    logic [7:0] command;
    logic [7:0] instruction;
    logic [8:0] rx_in;
    logic [7:0] ry_in;

    assign command     = s_tdata[7:0];
    assign instruction = s_tdata[15:8];
    assign rx_in       = s_tdata[152:144];
    assign ry_in       = s_tdata[160:153];

    assign s_tready  = !clearing && (!hold_valid_reg || cmd_ready);
    assign cmd_valid = hold_valid_reg;
    assign cmd       = hold_reg;

    always_comb
    begin
        cls.data = s_tdata[143:16];
        cls.rx   = (rx_in > 9'(FRAME_W - 1)) ? 9'(FRAME_W - 1) : rx_in;
        cls.ry   = (ry_in > 8'(FRAME_H - 1)) ? 8'(FRAME_H - 1) : ry_in;
        if (s_tuser) begin
            cls.op = OP_READ;
        end else if (command[5:0] != GFX_COMMAND) begin
            cls.op = OP_NOT_GFX;
        end else begin
            unique case (instruction[5:0])
                INS_MEM_PRESET:    cls.op = (s_tdata[27:24] == 4'd0) ? OP_MEM_PRESET : OP_NOP;
                INS_BORDER:        cls.op = OP_BORDER;
                INS_TILE:          cls.op = OP_TILE;
                INS_TILE_XOR:      cls.op = OP_TILE_XOR;
                INS_PAL_LOW:       cls.op = OP_PAL_LOW;
                INS_PAL_HIGH:      cls.op = OP_PAL_HIGH;
                INS_SCROLL_PRESET: cls.op = OP_SCROLL_PRESET;
                INS_SCROLL_COPY:   cls.op = OP_SCROLL_COPY;
                default:           cls.op = OP_UNKNOWN;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hold_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            hold_valid_reg <= 1'b1;
        end else if (cmd_ready) begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready) begin
            hold_reg <= cls;
        end
    end

endmodule

[rtl/cdg_fifo.sv]
module cdg_fifo
    import cdg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cdg_cmd_t in_cmd,
    input  logic     in_valid,
    output logic     in_ready,
    output cdg_cmd_t out_cmd,
    output logic     out_valid,
    input  logic     out_ready
);

    cdg_cmd_t   slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

[rtl/cdg_engine.sv]
`include "assert_macros.svh"

module cdg_engine
    import cdg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cdg_cmd_t    cmd,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    output logic        clearing,
    output cdg_result_t res,
    output logic        res_valid,
    input  logic        res_ready
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SWEEP = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_RDA   = 3'd3;
    localparam logic [2:0] S_RDB   = 3'd4;

    function automatic logic [23:0] pal_entry(input logic [7:0] hi, input logic [7:0] lo);
        logic [3:0] r;
        logic [3:0] g;
        logic [3:0] b;
        r = hi[5:2];
        g = {hi[1:0], lo[5:4]};
        b = lo[3:0];
        return {r, r, g, g, b, b};
    endfunction

    // Two frame banks; a scroll reads one and writes the other.
    logic [3:0] mem [0:131071];

    logic [2:0]   state_reg;
    logic         clearing_reg;
    logic         bank_reg;
    logic [2:0]   fine_h_reg;
    logic [3:0]   fine_v_reg;
    logic [23:0]  pal_reg [16];
    logic [3:0]   op_reg;
    logic [3:0]   col_reg;
    logic [127:0] data_reg;
    logic [8:0]   rx_reg;
    logic [7:0]   ry_reg;
    logic [8:0]   x_reg;
    logic [7:0]   y_reg;
    logic [8:0]   x_max_reg;
    logic [7:0]   y_max_reg;
    logic [8:0]   bx_reg;
    logic [7:0]   by_reg;
    logic signed [4:0] hs_reg;
    logic signed [5:0] vs_reg;
    logic         p1_valid_reg;
    logic         p1_we_reg;
    logic         p1_sel_reg;
    logic [3:0]   p1_col_reg;
    logic [16:0]  p1_addr_reg;
    logic [3:0]   rd_q_reg;
    logic         out_valid_reg;
    cdg_result_t  out_reg;

    logic        pop;
    logic        is_scroll;
    logic [8:0]  px;
    logic [7:0]  py;
    logic [15:0] waddr;
    logic signed [10:0] sx;
    logic signed [9:0]  sy;
    logic        wrap;
    logic [8:0]  sxm;
    logic [7:0]  sym;
    logic [16:0] raddr;
    logic [3:0]  bsel;
    logic [7:0]  tbyte;
    logic [3:0]  tcol;
    logic        w_we;
    logic        w_sel;
    logic [3:0]  w_col;
    logic        last;
    logic [3:0]  wdata;
    logic [8:0]  tile_row;
    logic [8:0]  tile_col;
    logic        tile_oor;
    logic [2:0]  h_new;
    logic [3:0]  v_new;
    logic signed [4:0] h_coarse;
    logic signed [5:0] v_coarse;
    logic signed [4:0] hs_new;
    logic signed [5:0] vs_new;
    logic        res_load;
    cdg_result_t res_data;

    assign clearing  = clearing_reg;
    assign res       = out_reg;
    assign res_valid = out_valid_reg;
    assign cmd_ready = (state_reg == S_IDLE) && !clearing_reg
                       && (!out_valid_reg || res_ready);
    assign pop       = cmd_ready && cmd_valid;
    assign is_scroll = (op_reg == OP_SCROLL_PRESET) || (op_reg == OP_SCROLL_COPY);
    assign last      = (x_reg == x_max_reg) && (y_reg == y_max_reg);

    // Sweep addressing and per-pixel write decision.
    always_comb
    begin
        px    = bx_reg + x_reg;
        py    = by_reg + y_reg;
        waddr = 16'(py) * 16'(FRAME_W) + 16'(px);
        sx    = $signed({2'b00, x_reg}) - 11'(hs_reg);
        sy    = $signed({2'b00, y_reg}) - 10'(vs_reg);
        wrap  = (sx < 0) || (sx >= 11'sd300) || (sy < 0) || (sy >= 10'sd216);
        if (sx < 0) begin
            sxm = 9'(sx + 11'sd300);
        end else if (sx >= 11'sd300) begin
            sxm = 9'(sx - 11'sd300);
        end else begin
            sxm = 9'(sx);
        end
        if (sy < 0) begin
            sym = 8'(sy + 10'sd216);
        end else if (sy >= 10'sd216) begin
            sym = 8'(sy - 10'sd216);
        end else begin
            sym = 8'(sy);
        end
        if (state_reg == S_RDA) begin
            raddr = {bank_reg, 16'(ry_reg) * 16'(FRAME_W) + 16'(rx_reg)};
        end else if (is_scroll) begin
            raddr = {bank_reg, 16'(sym) * 16'(FRAME_W) + 16'(sxm)};
        end else begin
            raddr = {bank_reg, waddr};
        end
        bsel  = 4'd4 + y_reg[3:0];
        tbyte = data_reg[bsel * 8 +: 8];
        tcol  = tbyte[3'd5 - x_reg[2:0]] ? data_reg[11:8] : data_reg[3:0];
        w_we  = 1'b1;
        w_sel = 1'b0;
        w_col = col_reg;
        case (op_reg)
            OP_BORDER:
            begin
                w_we = (py < 8'(BORDER_H)) || (py >= 8'(FRAME_H - BORDER_H))
                       || (px < 9'(BORDER_W)) || (px >= 9'(FRAME_W - BORDER_W));
            end
            OP_TILE:
            begin
                w_col = tcol;
            end
            OP_TILE_XOR:
            begin
                w_sel = 1'b1;
                w_col = tcol;
            end
            OP_SCROLL_PRESET:
            begin
                w_sel = !wrap;
                w_col = wrap ? col_reg : 4'd0;
            end
            OP_SCROLL_COPY:
            begin
                w_sel = 1'b1;
                w_col = 4'd0;
            end
            default:
            begin
                w_we = 1'b1;
            end
        endcase
    end

    assign wdata = p1_sel_reg ? (rd_q_reg ^ p1_col_reg) : p1_col_reg;

    // Decode of a newly popped command.
    always_comb
    begin
        tile_row = 9'(cmd.data[20:16]) * 9'(BORDER_H) + 9'(fine_v_reg);
        tile_col = 9'(cmd.data[29:24]) * 9'(BORDER_W) + 9'(fine_h_reg);
        tile_oor = (tile_row > 9'(FRAME_H - BORDER_H)) || (tile_col > 9'(FRAME_W - BORDER_W));
        h_new    = (cmd.data[10:8] > 3'd5) ? 3'd5 : cmd.data[10:8];
        v_new    = (cmd.data[19:16] > 4'd11) ? 4'd11 : cmd.data[19:16];
        case (cmd.data[13:12])
            2'd1:    h_coarse = 5'sd6;
            2'd2:    h_coarse = -5'sd6;
            default: h_coarse = 5'sd0;
        endcase
        case (cmd.data[21:20])
            2'd1:    v_coarse = 6'sd12;
            2'd2:    v_coarse = -6'sd12;
            default: v_coarse = 6'sd0;
        endcase
        hs_new = h_coarse + $signed({2'b00, h_new}) - $signed({2'b00, fine_h_reg});
        vs_new = v_coarse + $signed({2'b00, v_new}) - $signed({2'b00, fine_v_reg});
    end

    // Result selection.
    always_comb
    begin
        res_load = 1'b0;
        res_data = '{status: STAT_APPLIED, index: 4'd0, rgb: 24'd0};
        if (pop) begin
            unique case (cmd.op)
                OP_NOT_GFX:
                begin
                    res_load        = 1'b1;
                    res_data.status = STAT_NOT_GFX;
                end
                OP_UNKNOWN:
                begin
                    res_load        = 1'b1;
                    res_data.status = STAT_UNKNOWN;
                end
                OP_NOP, OP_PAL_LOW, OP_PAL_HIGH:
                begin
                    res_load = 1'b1;
                end
                OP_TILE, OP_TILE_XOR:
                begin
                    res_load        = tile_oor;
                    res_data.status = STAT_RANGE;
                end
                OP_SCROLL_PRESET, OP_SCROLL_COPY:
                begin
                    res_load = (hs_new == 5'sd0) && (vs_new == 6'sd0);
                end
                default:
                begin
                    res_load = 1'b0;
                end
            endcase
        end else if (state_reg == S_DRAIN) begin
            res_load = !clearing_reg;
        end else if (state_reg == S_RDB) begin
            res_load        = 1'b1;
            res_data.status = STAT_READ;
            res_data.index  = rd_q_reg;
            res_data.rgb    = pal_reg[rd_q_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_SWEEP;
            clearing_reg  <= 1'b1;
            bank_reg      <= 1'b0;
            fine_h_reg    <= 3'd0;
            fine_v_reg    <= 4'd0;
            op_reg        <= OP_MEM_PRESET;
            col_reg       <= 4'd0;
            x_reg         <= 9'd0;
            y_reg         <= 8'd0;
            x_max_reg     <= 9'(FRAME_W - 1);
            y_max_reg     <= 8'(FRAME_H - 1);
            bx_reg        <= 9'd0;
            by_reg        <= 8'd0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 16; i++) begin
                pal_reg[i] <= 24'd0;
            end
        end else begin
            p1_valid_reg <= (state_reg == S_SWEEP);
            if (res_load) begin
                out_valid_reg <= 1'b1;
            end else if (res_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop) begin
                        op_reg    <= cmd.op;
                        col_reg   <= cmd.data[3:0];
                        x_reg     <= 9'd0;
                        y_reg     <= 8'd0;
                        bx_reg    <= 9'd0;
                        by_reg    <= 8'd0;
                        x_max_reg <= 9'(FRAME_W - 1);
                        y_max_reg <= 8'(FRAME_H - 1);
                        case (cmd.op)
                            OP_READ:
                            begin
                                state_reg <= S_RDA;
                            end
                            OP_MEM_PRESET, OP_BORDER:
                            begin
                                state_reg <= S_SWEEP;
                            end
                            OP_TILE, OP_TILE_XOR:
                            begin
                                bx_reg    <= tile_col;
                                by_reg    <= tile_row[7:0];
                                x_max_reg <= 9'(BORDER_W - 1);
                                y_max_reg <= 8'(BORDER_H - 1);
                                if (!tile_oor) begin
                                    state_reg <= S_SWEEP;
                                end
                            end
                            OP_SCROLL_PRESET, OP_SCROLL_COPY:
                            begin
                                fine_h_reg <= h_new;
                                fine_v_reg <= v_new;
                                if ((hs_new != 5'sd0) || (vs_new != 6'sd0)) begin
                                    state_reg <= S_SWEEP;
                                end
                            end
                            OP_PAL_LOW, OP_PAL_HIGH:
                            begin
                                for (int i = 0; i < 8; i++) begin
                                    pal_reg[(cmd.op == OP_PAL_HIGH) ? i + 8 : i] <=
                                        pal_entry(cmd.data[16 * i +: 8], cmd.data[16 * i + 8 +: 8]);
                                end
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SWEEP:
                begin
                    if (x_reg == x_max_reg) begin
                        x_reg <= 9'd0;
                        y_reg <= y_reg + 8'd1;
                    end else begin
                        x_reg <= x_reg + 9'd1;
                    end
                    if (last) begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (is_scroll) begin
                        bank_reg <= ~bank_reg;
                    end
                    clearing_reg <= 1'b0;
                    state_reg    <= S_IDLE;
                end
                S_RDA:
                begin
                    state_reg <= S_RDB;
                end
                S_RDB:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            data_reg <= cmd.data;
            rx_reg   <= cmd.rx;
            ry_reg   <= cmd.ry;
            hs_reg   <= hs_new;
            vs_reg   <= vs_new;
        end
        p1_we_reg   <= w_we;
        p1_sel_reg  <= w_sel;
        p1_col_reg  <= w_col;
        p1_addr_reg <= {is_scroll ? ~bank_reg : bank_reg, waddr};
        if (res_load) begin
            out_reg <= res_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_valid_reg && p1_we_reg) begin
            mem[p1_addr_reg] <= wdata;
        end
        rd_q_reg <= mem[raddr];
    end

    `CDG_ASSERT(a_pop_idle, clk, rst_n, pop |-> (state_reg == S_IDLE && !clearing_reg))
    `CDG_ASSERT(a_scroll_bank, clk, rst_n, (state_reg == S_SWEEP && is_scroll) |=> (p1_addr_reg[16] != bank_reg))
    `CDG_ASSERT_ALWAYS(a_clear_quiet, clk, !(clearing_reg && out_valid_reg))

endmodule

[rtl/cdg_packet_decoder_core.sv]
// CD+G subcode graphics decoder.
// The slave channel takes one request per transfer: a subcode packet (tuser low)
// or a pixel read (tuser high). The master channel returns exactly one answer per
// request, in order, carrying a status code, and for reads the palette index and
// its RGB colour. A front end classifies each request into a two-entry queue; an
// engine owning the two-bank frame store and the palette carries it out.
// Palette loads and rejected packets are answered as the engine pops them, a
// pixel read through states S_RDA and S_RDB, and a tile block, memory preset,
// border preset or non-zero scroll once the one-pixel-per-cycle sweep of the
// frame store through its single write port is done. The engine takes a new
// request only once it is through with the one in hand. After reset the engine
// sweeps bank 0 to zero, during which s_tready stays low; the palette and fine
// scroll offsets reset at once.
// A stalled receiver keeps the answer in the output register; the engine starts
// the next request only once that register is free, while the front end and the
// queue go on taking up to three further requests.
module cdg_packet_decoder_core
    import cdg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command, instruction, data_low, data_high, read_x, read_y; zero padded
    input  logic [167:0] s_tdata,
    // kind
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, pixel_index, pixel_rgb; zero padded
    output logic [31:0]  m_tdata
);

    cdg_cmd_t    front_cmd;
    logic        front_valid;
    logic        front_ready;
    cdg_cmd_t    queue_cmd;
    logic        queue_valid;
    logic        queue_ready;
    logic        clearing;
    cdg_result_t result;

    cdg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .clearing  (clearing),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready)
    );

    cdg_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_cmd    (front_cmd),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .out_cmd   (queue_cmd),
        .out_valid (queue_valid),
        .out_ready (queue_ready)
    );

    cdg_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (queue_cmd),
        .cmd_valid (queue_valid),
        .cmd_ready (queue_ready),
        .clearing  (clearing),
        .res       (result),
        .res_valid (m_tvalid),
        .res_ready (m_tready)
    );

    // Status in the lowest bits, then the index and the colour.
    assign m_tdata = {1'b0, result.rgb, result.index, result.status};

endmodule
